/* rtl/format_directed_integer_printer_defines.svh */
// assertion helpers shared by the top level
`ifndef FORMAT_DIRECTED_INTEGER_PRINTER_DEFINES_SVH
`define FORMAT_DIRECTED_INTEGER_PRINTER_DEFINES_SVH

`define FDIP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define FDIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/fdip_pkg.sv */
package fdip_pkg;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LO    = 8'h6f;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LU    = 8'h75;
   localparam logic [7:0] CH_LC    = 8'h63;
   localparam logic [7:0] CH_LD    = 8'h64;

   localparam logic [1:0] PAD_RIGHT = 2'd0;
   localparam logic [1:0] PAD_LEFT  = 2'd1;
   localparam logic [1:0] PAD_ZERO  = 2'd2;

   localparam logic [2:0] RDX_BIN = 3'd0;
   localparam logic [2:0] RDX_OCT = 3'd1;
   localparam logic [2:0] RDX_HEX = 3'd2;
   localparam logic [2:0] RDX_HXU = 3'd3;
   localparam logic [2:0] RDX_DEC = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture value, start conversion
      logic [2:0] radix;
      logic       negate;     // use magnitude of signed value
      logic       step;       // one digit extraction
      logic       pop;        // drop one digit from the stack
   } dp_cmd_type;

   typedef struct packed {
      logic       done;       // value fully reduced
      logic [5:0] count;      // digits held
      logic [7:0] top_char;   // most significant digit held
      logic       neg;        // value was negative
   } dp_sts_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) c = CH_ZERO + {4'd0, d};
      else if (upper) c = 8'h37 + {4'd0, d};
      else c = 8'h57 + {4'd0, d};
      return c;
   endfunction

endpackage

/* rtl/fdip_if.sv */
interface fdip_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fmt_char;
   logic signed [31:0] arg_value;
   modport source (output valid, fmt_char, arg_value, input ready);
   modport sink (input valid, fmt_char, arg_value, output ready);
endinterface

interface fdip_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       error;
   modport source (output valid, out_char, last, error, input ready);
   modport sink (input valid, out_char, last, error, output ready);
endinterface

/* rtl/fdip_datapath.sv */
module fdip_datapath (
   input  logic                clock,
   input  logic                reset,
   input  fdip_pkg::dp_cmd_type cmd,
   input  logic [31:0]         value,
   output fdip_pkg::dp_sts_type sts
);
   logic [31:0] val_ff, val_in;
   logic [2:0]  rdx_ff, rdx_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [7:0]  stk_ff [32];
   logic [7:0]  digit;
   logic [31:0] quot;
   logic [63:0] prod;
   logic [31:0] rem;

   // divide by ten: reciprocal multiply, then one correction
   always_comb begin
      prod = {32'd0, val_ff} * 64'd3435973837;
      quot = {3'd0, prod[63:35]};
      rem = val_ff - 32'(quot * 32'd10);
      if (rem >= 32'd10) begin
         quot = quot + 32'd1;
         rem = rem - 32'd10;
      end
      digit = fdip_pkg::CH_ZERO;
      unique case (rdx_ff)
         fdip_pkg::RDX_BIN: digit = fdip_pkg::hex_char({3'd0, val_ff[0]}, 1'b0);
         fdip_pkg::RDX_OCT: digit = fdip_pkg::hex_char({1'b0, val_ff[2:0]}, 1'b0);
         fdip_pkg::RDX_HEX: digit = fdip_pkg::hex_char(val_ff[3:0], 1'b0);
         fdip_pkg::RDX_HXU: digit = fdip_pkg::hex_char(val_ff[3:0], 1'b1);
         default:           digit = fdip_pkg::hex_char(rem[3:0], 1'b0);
      endcase
   end

   always_comb begin
      val_in = val_ff;
      rdx_in = rdx_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         neg_in = cmd.negate & value[31];
         val_in = neg_in ? 32'(-value) : value;
         rdx_in = cmd.radix;
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 6'd1;
         unique case (rdx_ff) inside
            fdip_pkg::RDX_BIN: val_in = val_ff >> 1;
            fdip_pkg::RDX_OCT: val_in = val_ff >> 3;
            fdip_pkg::RDX_HEX, fdip_pkg::RDX_HXU: val_in = val_ff >> 4;
            default: val_in = quot;
         endcase
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      val_ff <= val_in;
      rdx_ff <= rdx_in;
      neg_ff <= neg_in;
      if (cmd.step && !cmd.load) stk_ff[cnt_ff[4:0]] <= digit;
   end

   // done once at least one digit is out and nothing remains
   assign sts.done = (cnt_ff != 6'd0) && (val_ff == 32'd0);
   assign sts.count = cnt_ff;
   assign sts.top_char = stk_ff[5'(cnt_ff - 6'd1)];
   assign sts.neg = neg_ff;
endmodule

/* rtl/fdip_ctrl.sv */
module fdip_ctrl #(
   parameter int MAX_WIDTH = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   fdip_req_if.sink             req,
   fdip_rsp_if.source           rsp,
   output fdip_pkg::dp_cmd_type cmd,
   input  fdip_pkg::dp_sts_type sts
);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_PRE  = 3'd2;  // sign and left pad
   localparam logic [2:0] S_DIG  = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;  // right pad then hash
   localparam logic [2:0] S_ONE  = 3'd5;  // single character pending

   logic [2:0]    st_ff, st_in;
   logic          pct_ff, pct_in;
   logic [1:0]    pad_ff, pad_in;
   logic [WW-1:0] wid_ff, wid_in;
   logic          wst_ff, wst_in, wcl_ff, wcl_in;
   logic          isd_ff, isd_in;
   logic          sgn_ff, sgn_in;      // sign still to print
   logic [WW-1:0] fill_ff, fill_in;
   logic [7:0]    ch_ff, ch_in;
   logic          err_ff, err_in;
   logic          ov_ff, ov_in;
   logic [7:0]    oc_ff, oc_in;
   logic          ol_ff, ol_in, oe_ff, oe_in;
   logic          take;
   logic          fire;
   logic [WW+3:0] wmul;
   logic [6:0]    ncnt;

   assign take = req.valid && req.ready;
   assign req.ready = (st_ff == S_IDLE) && !ov_ff;
   assign fire = !ov_ff || rsp.ready;
   assign rsp.valid = ov_ff;
   assign rsp.out_char = oc_ff;
   assign rsp.last = ol_ff;
   assign rsp.error = oe_ff;
   assign ncnt = {1'b0, sts.count} + {6'd0, sts.neg};

   always_comb begin
      st_in = st_ff; pct_in = pct_ff; pad_in = pad_ff; wid_in = wid_ff;
      wst_in = wst_ff; wcl_in = wcl_ff; isd_in = isd_ff; sgn_in = sgn_ff;
      fill_in = fill_ff; ch_in = ch_ff; err_in = err_ff;
      ov_in = ov_ff && !rsp.ready; oc_in = oc_ff; ol_in = ol_ff; oe_in = oe_ff;
      cmd = '0;
      wmul = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (take) begin
               if (!pct_ff) begin
                  if (req.fmt_char == fdip_pkg::CH_PCT) pct_in = 1'b1;
                  else begin
                     ch_in = req.fmt_char; err_in = 1'b0; st_in = S_ONE;
                  end
               end else if (req.fmt_char == fdip_pkg::CH_MINUS ||
                            (req.fmt_char >= fdip_pkg::CH_ZERO &&
                             req.fmt_char <= fdip_pkg::CH_NINE)) begin
                  if (!wst_ff) begin
                     wst_in = 1'b1;
                     if (req.fmt_char == fdip_pkg::CH_MINUS) pad_in = fdip_pkg::PAD_LEFT;
                     else begin
                        pad_in = (req.fmt_char == fdip_pkg::CH_ZERO) ?
                                 fdip_pkg::PAD_ZERO : fdip_pkg::PAD_RIGHT;
                        wmul = (WW+4)'(req.fmt_char - fdip_pkg::CH_ZERO);
                        wid_in = (wmul > (WW+4)'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wmul);
                     end
                  end else if (req.fmt_char == fdip_pkg::CH_MINUS) wcl_in = 1'b1;
                  else if (!wcl_ff) begin
                     wmul = (WW+4)'(wid_ff) * (WW+4)'(10)
                          + (WW+4)'(req.fmt_char - fdip_pkg::CH_ZERO);
                     wid_in = (wmul > (WW+4)'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wmul);
                  end
               end else begin
                  pct_in = 1'b0;
                  isd_in = 1'b0;
                  case (req.fmt_char) inside
                     fdip_pkg::CH_PCT: begin
                        ch_in = fdip_pkg::CH_PCT; err_in = 1'b0; st_in = S_ONE;
                     end
                     fdip_pkg::CH_LC: begin
                        ch_in = req.arg_value[7:0]; err_in = 1'b0; st_in = S_ONE;
                     end
                     fdip_pkg::CH_LB, fdip_pkg::CH_LO, fdip_pkg::CH_LX,
                     fdip_pkg::CH_UX, fdip_pkg::CH_LU, fdip_pkg::CH_LD: begin
                        cmd.load = 1'b1;
                        cmd.negate = (req.fmt_char == fdip_pkg::CH_LD);
                        isd_in = cmd.negate;
                        case (req.fmt_char)
                           fdip_pkg::CH_LB: cmd.radix = fdip_pkg::RDX_BIN;
                           fdip_pkg::CH_LO: cmd.radix = fdip_pkg::RDX_OCT;
                           fdip_pkg::CH_LX: cmd.radix = fdip_pkg::RDX_HEX;
                           fdip_pkg::CH_UX: cmd.radix = fdip_pkg::RDX_HXU;
                           default:         cmd.radix = fdip_pkg::RDX_DEC;
                        endcase
                        st_in = S_CONV;
                     end
                     default: begin
                        ch_in = req.fmt_char; err_in = 1'b1; st_in = S_ONE;
                     end
                  endcase
               end
            end
         end
         S_ONE: begin
            if (fire) begin
               ov_in = 1'b1; oc_in = ch_ff; ol_in = 1'b1; oe_in = err_ff;
               st_in = S_IDLE;
            end
         end
         S_CONV: begin
            if (sts.done) begin
               sgn_in = sts.neg;
               fill_in = '0;
               if (isd_ff && wst_ff && wid_ff != '0 &&
                   ncnt < {{(7-WW){1'b0}}, wid_ff}) begin
                  fill_in = WW'({{(7-WW){1'b0}}, wid_ff} - ncnt);
               end
               st_in = S_PRE;
            end else cmd.step = 1'b1;
         end
         S_PRE: begin
            if (fire) begin
               if (pad_ff == fdip_pkg::PAD_LEFT && fill_ff != '0) begin
                  ov_in = 1'b1; oc_in = fdip_pkg::CH_SPACE; ol_in = 1'b0; oe_in = 1'b0;
                  fill_in = fill_ff - WW'(1);
               end else if (sgn_ff) begin
                  ov_in = 1'b1; oc_in = fdip_pkg::CH_MINUS; ol_in = 1'b0; oe_in = 1'b0;
                  sgn_in = 1'b0;
               end else if (pad_ff == fdip_pkg::PAD_ZERO && fill_ff != '0) begin
                  ov_in = 1'b1; oc_in = fdip_pkg::CH_ZERO; ol_in = 1'b0; oe_in = 1'b0;
                  fill_in = fill_ff - WW'(1);
               end else st_in = S_DIG;
            end
         end
         S_DIG: begin
            if (fire) begin
               ov_in = 1'b1; oc_in = sts.top_char; oe_in = 1'b0;
               cmd.pop = 1'b1;
               ol_in = (sts.count == 6'd1) &&
                       !(pad_ff == fdip_pkg::PAD_RIGHT && fill_ff != '0);
               if (sts.count == 6'd1) st_in = ol_in ? S_IDLE : S_POST;
            end
         end
         S_POST: begin
            if (fire) begin
               ov_in = 1'b1; ol_in = 1'b0; oe_in = 1'b0;
               if (fill_ff != '0) begin
                  oc_in = fdip_pkg::CH_SPACE; fill_in = fill_ff - WW'(1);
               end else begin
                  oc_in = fdip_pkg::CH_HASH; ol_in = 1'b1; st_in = S_IDLE;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
      // a finished signed decimal (d) conversion clears the width state
      if (st_ff != S_IDLE && st_in == S_IDLE && isd_ff) begin
         pad_in = fdip_pkg::PAD_RIGHT; wid_in = '0; wst_in = 1'b0; wcl_in = 1'b0;
         isd_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pct_ff <= 1'b0; pad_ff <= fdip_pkg::PAD_RIGHT;
         wid_ff <= '0; wst_ff <= 1'b0; wcl_ff <= 1'b0; isd_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; pct_ff <= pct_in; pad_ff <= pad_in; wid_ff <= wid_in;
         wst_ff <= wst_in; wcl_ff <= wcl_in; isd_ff <= isd_in; ov_ff <= ov_in;
      end
      sgn_ff <= sgn_in; fill_ff <= fill_in; ch_ff <= ch_in; err_ff <= err_in;
      oc_ff <= oc_in; ol_ff <= ol_in; oe_ff <= oe_in;
   end
endmodule

/* rtl/format_directed_integer_printer.sv */
// channel | dir | payload
// req     | in  | fmt_char, arg_value
// rsp     | out | out_char, last, error
// a conversion extracts its digits in the datapath (divide by ten for d and u), then prints
// each character through the output register.
// a plain character passes through S_ONE and the output register before the next beat is taken;
// flags and width digits are absorbed while idle.
// reset is synchronous and returns to plain text mode with the width cleared.
// rsp stalls hold the controller; req is taken only when nothing is in flight.
`include "format_directed_integer_printer_defines.svh"
module format_directed_integer_printer #(
   parameter int MAX_WIDTH = 31
) (
   input logic        clock,
   input logic        reset,
   fdip_req_if.sink   req,
   fdip_rsp_if.source rsp
);
   fdip_pkg::dp_cmd_type cmd;
   fdip_pkg::dp_sts_type sts;

   fdip_datapath u_dp (.clock(clock), .reset(reset), .cmd(cmd), .value(req.arg_value),
                       .sts(sts));
   fdip_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (.clock(clock), .reset(reset), .req(req),
                                              .rsp(rsp), .cmd(cmd), .sts(sts));

   `FDIP_ASSERT_IMPL(a_no_pop_empty, clock, reset, cmd.pop, sts.count != 6'd0)
   `FDIP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready,
                     rsp.valid && $stable(rsp.out_char))
   `FDIP_ASSERT_IMPL(a_digits_fit, clock, reset, 1'b1, sts.count <= 6'd32)
endmodule
